/* hw/rtl/las_pkg.sv */
// Shared widths, defaults and types for the atanh-series log pipeline.
package las_pkg;

	localparam int WORK_BITS        = 30;  // fraction bits of t, t^2, y and log
	localparam int DATA_W           = 32;  // operand and result width
	localparam int LOG_W            = 33;  // series log magnitude width
	localparam int Y_W              = 32;  // Horner accumulator width
	localparam int DEF_SERIES_TERMS = 15;
	localparam int DEF_FRAC_BITS    = 16;

	typedef struct packed {
		logic [LOG_W-1:0] mag;
		logic             neg;
	} log_out_t;

endpackage

/* hw/rtl/log_atanh_series.sv */
// Top level of the truncated atanh-series logarithm pipeline.
//
//  channel  | handshake        | ports
//  ---------+------------------+------------------------------
//  command  | start, busy      | mode, arg, base
//  result   | done (strobe)    | value, div_error
//
// One beat enters per cycle; busy is held low, the pipeline never stops.
// Each beat passes the two log units (divide for t, square, one Horner step
// per term, final scale), then the bit-per-stage quotient of mode 1 with
// LOG_W + FRAC_BITS stages, then one output register.
// Reset clears only the valid bits and div_error; the data path carries no reset.
// Results appear for one cycle on done; the receiver cannot stall them.
module log_atanh_series #(
	parameter int SERIES_TERMS = las_pkg::DEF_SERIES_TERMS,
	parameter int FRAC_BITS    = las_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              mode,
	input  logic        [las_pkg::DATA_W-1:0] arg,
	input  logic        [las_pkg::DATA_W-1:0] base,
	output logic                              done,
	output logic signed [las_pkg::DATA_W-1:0] value,
	output logic                              div_error
);

	localparam int WB     = las_pkg::WORK_BITS;
	localparam int LW     = las_pkg::LOG_W;
	localparam int DW     = las_pkg::DATA_W;
	localparam int QW     = LW + FRAC_BITS;   // quotient bits of mode 1
	localparam int LogLat = SERIES_TERMS + 33;

	localparam logic [QW-1:0] NEG_LIM = QW'(64'h8000_0000);
	localparam logic [QW-1:0] POS_LIM = QW'(64'h7FFF_FFFF);

	function automatic logic [DW-1:0] sat32(input logic [QW-1:0] mag, input logic neg);
		logic [DW-1:0] r;
		if (neg) begin
			r = (mag >= NEG_LIM) ? 32'h8000_0000 : (32'd0 - mag[DW-1:0]);
		end else begin
			r = (mag > POS_LIM) ? 32'h7FFF_FFFF : mag[DW-1:0];
		end
		return r;
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// two log units in lockstep
	las_pkg::log_out_t la;
	las_pkg::log_out_t lb;

	las_series_log #(.SERIES_TERMS(SERIES_TERMS), .FRAC_BITS(FRAC_BITS)) u_log_arg (
		.clk (clk),
		.a   (arg),
		.res (la)
	);

	las_series_log #(.SERIES_TERMS(SERIES_TERMS), .FRAC_BITS(FRAC_BITS)) u_log_base (
		.clk (clk),
		.a   (base),
		.res (lb)
	);

	// valid and mode ride alongside the log units
	logic [LogLat-1:0] vl_q;
	logic [LogLat-1:0] ml_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q <= '0;
		end else begin
			vl_q <= {vl_q[LogLat-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		ml_q <= {ml_q[LogLat-2:0], mode};
	end

	// mode 1 quotient: one bit per stage, numerator shifts out as quotient shifts in
	logic          vd_s [1:QW];
	logic          md_s [1:QW];
	logic [LW-1:0] r_s  [1:QW];
	logic [QW-1:0] nq_s [1:QW];
	logic [LW-1:0] dv_s [1:QW];
	logic          sg_s [1:QW];
	logic [DW-1:0] v0_s [1:QW];
	logic          dz_s [1:QW];

	for (genvar gj = 0; gj < QW; gj++) begin : g_qdiv
		logic          vd_i, md_i, sg_i, dz_i, ge;
		logic [LW-1:0] r_i, dv_i;
		logic [QW-1:0] nq_i;
		logic [DW-1:0] v0_i;
		logic [LW:0]   rs, rsub;

		if (gj == 0) begin : g_head
			assign vd_i = vl_q[LogLat-1];
			assign md_i = ml_q[LogLat-1];
			assign r_i  = '0;
			assign nq_i = {la.mag, {FRAC_BITS{1'b0}}};
			assign dv_i = lb.mag;
			assign sg_i = la.neg ^ lb.neg;
			assign v0_i = sat32(QW'(la.mag >> (WB - FRAC_BITS)), la.neg);
			assign dz_i = lb.mag == '0;
		end else begin : g_body
			assign vd_i = vd_s[gj];
			assign md_i = md_s[gj];
			assign r_i  = r_s[gj];
			assign nq_i = nq_s[gj];
			assign dv_i = dv_s[gj];
			assign sg_i = sg_s[gj];
			assign v0_i = v0_s[gj];
			assign dz_i = dz_s[gj];
		end

		assign rs   = {r_i, nq_i[QW-1]};
		assign ge   = rs >= {1'b0, dv_i};
		assign rsub = rs - {1'b0, dv_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[gj+1] <= 1'b0;
			end else begin
				vd_s[gj+1] <= vd_i;
			end
		end

		always_ff @(posedge clk) begin
			md_s[gj+1] <= md_i;
			r_s[gj+1]  <= ge ? rsub[LW-1:0] : rs[LW-1:0];
			nq_s[gj+1] <= {nq_i[QW-2:0], ge};
			dv_s[gj+1] <= dv_i;
			sg_s[gj+1] <= sg_i;
			v0_s[gj+1] <= v0_i;
			dz_s[gj+1] <= dz_i;
		end
	end

	// output register: pick mode 0 value, zero-divisor flag, or saturated quotient
	logic          done_q;
	logic [DW-1:0] value_q;
	logic          div_error_q;
	logic [QW-1:0] quo;
	logic [DW-1:0] val_nx;
	logic          err_nx;

	assign quo = nq_s[QW];

	always_comb begin
		if (!md_s[QW]) begin
			val_nx = v0_s[QW];
			err_nx = 1'b0;
		end else if (dz_s[QW]) begin
			val_nx = '0;
			err_nx = 1'b1;
		end else begin
			val_nx = sat32(quo, (quo != '0) && sg_s[QW]);
			err_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			div_error_q <= 1'b0;
		end else begin
			done_q      <= vd_s[QW];
			div_error_q <= vd_s[QW] & err_nx;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= val_nx;
	end

	assign done      = done_q;
	assign value     = value_q;
	assign div_error = div_error_q;

`ifndef SYNTHESIS
	a_err_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_error |-> done)
		else $error("div_error without done");

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_error) |-> (value == '0))
		else $error("div_error with nonzero value");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vd_s[QW] && md_s[QW] && (dv_s[QW] != '0)) |-> (r_s[QW] < dv_s[QW]))
		else $error("quotient remainder not below divisor");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vd_s[QW] |=> done)
		else $error("result beat lost at output register");
`endif

endmodule

/* hw/rtl/las_series_log.sv */
// Pipelined series log of one operand: restoring divide, square, Horner steps, final scale.
module las_series_log #(
	parameter int SERIES_TERMS = las_pkg::DEF_SERIES_TERMS,
	parameter int FRAC_BITS    = las_pkg::DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic [las_pkg::DATA_W-1:0] a,
	output las_pkg::log_out_t          res
);

	localparam int WB = las_pkg::WORK_BITS;
	localparam int LW = las_pkg::LOG_W;
	localparam int YW = las_pkg::Y_W;
	localparam int N  = SERIES_TERMS;

	localparam logic [LW-1:0] ONE = LW'(64'd1 << FRAC_BITS);
	localparam logic [YW-1:0] Y0  = YW'((64'd1 << WB) / (2 * SERIES_TERMS + 1));

	logic [LW-1:0] a_ext;
	logic [LW-1:0] diff;
	logic [LW-1:0] den;
	logic          below;
	logic          zero_a;

	assign a_ext  = {1'b0, a};
	assign below  = a_ext < ONE;
	assign diff   = below ? (ONE - a_ext) : (a_ext - ONE);
	assign den    = a_ext + ONE;
	assign zero_a = a == '0;

	// t = |a-1| * 2^30 / (a+1), one quotient bit per stage
	// zero operand: diff equals den, so t is exactly 1.0 (top bit set, remainder zero)
	logic [LW-1:0] r_s   [0:WB];
	logic [LW-1:0] den_s [0:WB];
	logic [WB:0]   q_s   [0:WB];
	logic          n_s   [0:WB];

	always_ff @(posedge clk) begin
		r_s[0]   <= zero_a ? '0 : diff;
		den_s[0] <= den;
		q_s[0]   <= {{WB{1'b0}}, zero_a};
		n_s[0]   <= below;
	end

	for (genvar gi = 0; gi < WB; gi++) begin : g_div
		logic [LW:0] rs;
		logic [LW:0] rsub;
		logic        ge;

		assign rs   = {r_s[gi], 1'b0};
		assign ge   = rs >= {1'b0, den_s[gi]};
		assign rsub = rs - {1'b0, den_s[gi]};

		always_ff @(posedge clk) begin
			r_s[gi+1]   <= ge ? rsub[LW-1:0] : rs[LW-1:0];
			den_s[gi+1] <= den_s[gi];
			q_s[gi+1]   <= {q_s[gi][WB-1:0], ge};
			n_s[gi+1]   <= n_s[gi];
		end
	end

	// t^2
	logic [2*WB+1:0] sq;
	logic [WB:0]     t_h  [0:N];
	logic [WB:0]     tt_h [0:N];
	logic            n_h  [0:N];

	assign sq = q_s[WB] * q_s[WB];

	always_ff @(posedge clk) begin
		t_h[0]  <= q_s[WB];
		tt_h[0] <= sq[2*WB:WB];
		n_h[0]  <= n_s[WB];
	end

	// Horner: y = 1/nk + t^2*y, nk from 2N-1 down to 1
	logic [YW-1:0] y_s [1:N];

	for (genvar gi = 0; gi < N; gi++) begin : g_horner
		localparam logic [YW-1:0] INV = YW'((64'd1 << WB) / (2 * (SERIES_TERMS - gi) - 1));
		logic [YW-1:0]  y_in;
		logic [WB+YW:0] prod;

		if (gi == 0) begin : g_first
			assign y_in = Y0;
		end else begin : g_next
			assign y_in = y_s[gi];
		end

		assign prod = tt_h[gi] * y_in;

		always_ff @(posedge clk) begin
			y_s[gi+1]  <= INV + prod[WB+YW-1:WB];
			t_h[gi+1]  <= t_h[gi];
			tt_h[gi+1] <= tt_h[gi];
			n_h[gi+1]  <= n_h[gi];
		end
	end

	// log = 2*t*y
	logic [WB+YW:0] fin;
	logic [LW-1:0]  mag;

	assign fin = t_h[N] * y_s[N];
	assign mag = fin[WB+YW-1:WB-1];

	always_ff @(posedge clk) begin
		res.mag <= mag;
		res.neg <= (mag != '0) && n_h[N];
	end

endmodule

/* tb/log_atanh_checker.sv */
// Scoreboard for log_atanh_series: predicts each command beat and checks each result beat.
module log_atanh_checker #(
	parameter int SERIES_TERMS = las_pkg::DEF_SERIES_TERMS,
	parameter int FRAC_BITS    = las_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              mode,
	input  logic        [las_pkg::DATA_W-1:0] arg,
	input  logic        [las_pkg::DATA_W-1:0] base,
	input  logic                              done,
	input  logic signed [las_pkg::DATA_W-1:0] value,
	input  logic                              div_error,
	output int                                pending,
	output int                                fails
);
	import las_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              div_error;
	} log_result_t;

	log_result_t expected_logs[$];

	// series magnitude with WORK_BITS fraction bits, sign and magnitude form
	function automatic void series_mag(input logic [DATA_W-1:0] a,
			output longint unsigned mag, output bit neg);
		longint unsigned one, diff, den, t, tt, y, nk;
		bit n;
		one = 64'd1 << FRAC_BITS;
		if (a >= one) begin
			diff = a - one;
			n = 1'b0;
		end else begin
			diff = one - a;
			n = 1'b1;
		end
		den = a + one;
		t = (diff << WORK_BITS) / den;
		tt = (t * t) >> WORK_BITS;
		nk = 2 * SERIES_TERMS + 1;
		y = (64'd1 << WORK_BITS) / nk;
		for (int k = SERIES_TERMS; k > 0; k--) begin
			nk -= 2;
			y = (64'd1 << WORK_BITS) / nk + ((tt * y) >> WORK_BITS);
		end
		mag = (2 * t * y) >> WORK_BITS;
		neg = (mag != 0) && n;
	endfunction

	function automatic logic [DATA_W-1:0] saturate(longint unsigned mag, bit neg);
		if (neg)
			return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
	endfunction

	function automatic log_result_t predict_log(logic m, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		log_result_t r;
		longint unsigned la, lb, q;
		bit na, nb;
		series_mag(a, la, na);
		r.div_error = 1'b0;
		if (!m) begin
			r.value = saturate(la >> (WORK_BITS - FRAC_BITS), na);
			return r;
		end
		series_mag(b, lb, nb);
		if (lb == 0) begin
			// base of one: divide by zero flagged, value forced to zero
			r.value = '0;
			r.div_error = 1'b1;
			return r;
		end
		q = (la << FRAC_BITS) / lb;
		r.value = saturate(q, (q != 0) && (na != nb));
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fails++;
	endtask

	initial begin
		fails   = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_logs.push_back(predict_log(mode, arg, base));
			if (done) begin
				if (expected_logs.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					log_result_t e;
					e = expected_logs.pop_front();
					if (value !== e.value)
						report_mismatch($sformatf("value %h, expected %h", value, e.value));
					if (div_error !== e.div_error)
						report_mismatch($sformatf("div_error %b, expected %b",
							div_error, e.div_error));
				end
			end
			pending = expected_logs.size();
		end
	end
endmodule

/* tb/tb_top.sv */
// Stimulus, watchdog and verdict for the log_atanh_series testbench.
module tb_top;
	import las_pkg::*;

	localparam int IDLE_LIMIT  = 5000; // cycles with no beat at all before giving up
	localparam int DRAIN_WAIT  = 200;  // comfortably above the pipeline latency
	localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;

	logic              clk, arst_n, start, busy, mode, done, div_error;
	logic [DATA_W-1:0] arg, base;
	logic signed [DATA_W-1:0] value;
	int                pending, fails, quiet;
	int                idle_pct;

	log_atanh_series uut (.*);

	log_atanh_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any accepted beat on either channel resets the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// drive one command beat at the falling edge, hold it until accepted
	task automatic send_cmd(logic m, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		@(negedge clk);
		start = 1'b1;
		mode  = m;
		arg   = a;
		base  = b;
		do @(posedge clk); while (busy);
		// optional gap after the beat, odds set by the current phase
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			arg   = $urandom;
			repeat ($urandom_range(12)) @(negedge clk);
		end
	endtask

	// operands: half the time near or at one where the series is meaningful, else anything
	function automatic logic [DATA_W-1:0] rand_operand();
		case ($urandom_range(5))
			0, 1:    return ONE + 32'($signed($urandom_range(65535)) - 32768);
			2:       return $urandom_range(ONE * 8);
			3:       return 32'($urandom) >> $urandom_range(31);
			4:       return ONE;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		quiet    = 0;
		idle_pct = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		mode     = 1'b0;
		arg      = '0;
		base     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, both modes, zero arg, zero base log
		send_cmd(1'b0, 32'h0000_0000, 32'h0000_0000);
		send_cmd(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(1'b0, ONE, $urandom);
		send_cmd(1'b0, 32'h0000_0001, 32'h0000_0000);
		send_cmd(1'b0, ONE - 1, $urandom);
		send_cmd(1'b0, ONE + 1, $urandom);
		send_cmd(1'b0, 32'h0002_B7E1, 32'hFFFF_FFFF);
		send_cmd(1'b0, 32'h8000_0000, 32'h5555_5555);
		send_cmd(1'b1, 32'h0002_0000, ONE);
		send_cmd(1'b1, 32'h0000_0000, ONE);
		send_cmd(1'b1, ONE, ONE);
		send_cmd(1'b1, 32'h0000_0000, 32'h0000_0000);
		send_cmd(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
		send_cmd(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
		send_cmd(1'b1, 32'hFFFF_FFFF, ONE + 1);
		send_cmd(1'b1, 32'hFFFF_FFFF, ONE - 1);
		send_cmd(1'b1, 32'h0000_8000, 32'h0004_0000);
		send_cmd(1'b1, 32'h0004_0000, 32'h0000_8000);
		send_cmd(1'b1, ONE, 32'h0002_0000);

		// random phases: no gaps, heavy gaps, no gaps, light gaps
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 88 : (ph == 3) ? 11 : 0;
			repeat (260)
				send_cmd(1'($urandom_range(1)), rand_operand(), rand_operand());
		end

		@(negedge clk);
		start = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
